// ===== rtl/bpp_pkg.sv =====
// Shared constants, register codes, status codes and the configuration record
// of the Boris particle push block. No dependencies.
package bpp_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_IN_FIELDS = 12;
  localparam int NUM_OUT_WORDS = 5;
  localparam int CFG_AW        = 4;
  localparam int CFG_DW        = 32;

  // floor(tan(22.5 deg) * 2^30)
  localparam logic [31:0] TAN_LIMIT_Q30 = 32'd444758425;

  localparam logic [30:0] TIME_STEP_RST   = 31'd655;
  localparam logic [30:0] CELL_LENGTH_RST = 31'd65536;

  typedef enum logic [1:0] {
    REG_TIME_STEP,
    REG_CELL_LENGTH,
    REG_HALF_STEP
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_ROT_FAULT,
    ST_CFL_WARN,
    ST_CFL_STOP
  } status_t;

  typedef struct packed {
    logic        half;
    logic [30:0] cell_length;
    logic [30:0] time_step;
  } cfg_t;

endpackage

// ===== rtl/bpp_cfg_regs.sv =====
// APB-style configuration registers of the Boris particle push block.
// Depends on bpp_pkg.
module bpp_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpp_pkg::CFG_AW-1:0] paddr,
  input  logic [bpp_pkg::CFG_DW-1:0] pwdata,
  output logic [bpp_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output bpp_pkg::cfg_t              cfg_o
);
  import bpp_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_TIME_STEP:   cfg_nxt.time_step   = pwdata[30:0];
        REG_CELL_LENGTH: cfg_nxt.cell_length = pwdata[30:0];
        REG_HALF_STEP:   cfg_nxt.half        = pwdata[0];
        default: begin
          // drop writes outside the register list
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TIME_STEP:   prdata = CFG_DW'(cfg_r.time_step);
      REG_CELL_LENGTH: prdata = CFG_DW'(cfg_r.cell_length);
      REG_HALF_STEP:   prdata = CFG_DW'(cfg_r.half);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_step   <= TIME_STEP_RST;
      cfg_r.cell_length <= CELL_LENGTH_RST;
      cfg_r.half        <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/bpp_div_stage.sv =====
// One restoring-division step (one quotient bit) of the s-vector divider.
// No dependencies.
module bpp_div_stage #(
  parameter int RW = 34,
  parameter int DW = 17,
  parameter int SH = 0
) (
  input  logic [RW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  output logic [RW-1:0] rem_o,
  output logic          qbit_o
);

  logic [RW-1:0] dsh;

  assign dsh    = RW'(den_i) << SH;
  assign qbit_o = (rem_i >= dsh);
  assign rem_o  = qbit_o ? (rem_i - dsh) : rem_i;

endmodule

// ===== rtl/bpp_core.sv =====
// Pipelined datapath of the Boris particle push: half step, kicks, rotation,
// divider for s, Courant check and position advance. Depends on bpp_pkg and
// bpp_div_stage.
module bpp_core #(
  parameter int WORD_BITS = bpp_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = bpp_pkg::FRAC_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  bpp_pkg::cfg_t                                cfg,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [bpp_pkg::NUM_IN_FIELDS*WORD_BITS-1:0]  in_item,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [bpp_pkg::NUM_OUT_WORDS*WORD_BITS-1:0]  out_item,
  output bpp_pkg::status_t                             out_status
);
  import bpp_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int PW    = ((W > 32) ? 2 * W : W + 32) + 2;
  localparam int RW    = 2 * F + 2;
  localparam int DW    = F + 1;
  localparam int QB    = F + 1;
  localparam int CW    = PW + 2;
  localparam int MGW   = ((W + 31 - F) > 32) ? (W + 31 - F) : 32;
  localparam int SDIV  = 6;
  localparam int SD    = SDIV + QB;
  localparam int NST   = SD + 6;
  localparam int LAST  = NST - 1;

  localparam logic signed [PW-1:0] WMAX_P = $signed((PW'(1) << (W - 1)) - PW'(1));
  localparam logic signed [PW-1:0] WMIN_P = -WMAX_P - $signed(PW'(1));
  localparam logic signed [PW-1:0] ONE_P  = $signed(PW'(1) << F);
  localparam logic [MGW-1:0]       TANL   = MGW'(TAN_LIMIT_Q30);

  typedef struct packed {
    logic [2:0][W-1:0]  vo;
    logic [2:0][W-1:0]  e;
    logic [2:0][W-1:0]  b;
    logic [W-1:0]       px;
    logic [W-1:0]       py;
    logic [PW-1:0]      p_hk;
    logic [5:0][PW-1:0] pc;
    logic [W-1:0]       hk;
    logic [2:0][W-1:0]  l;
    logic [2:0][PW-1:0] p_t;
    logic [2:0][PW-1:0] p_a;
    logic [2:0][PW-1:0] p_l;
    logic [2:0][W-1:0]  t;
    logic [2:0][W-1:0]  a;
    logic [2:0][W-1:0]  vh;
    logic               fault;
    logic [2:0][W-1:0]  vm;
    logic [2:0][PW-1:0] p_tt;
    logic [5:0][PW-1:0] pcx;
    logic [2:0][RW-1:0] rem;
    logic [2:0][DW-1:0] den;
    logic [2:0][W-1:0]  vd;
    logic [2:0][QB-1:0] q;
    logic [5:0][PW-1:0] p_s;
    logic [2:0][W-1:0]  vp;
    logic [2:0][W-1:0]  vf;
    logic [W+1:0]       sum;
    logic [PW-1:0]      p_px;
    logic [PW-1:0]      p_py;
    logic               pos;
    logic [CW-1:0]      p_c;
    logic [W-1:0]       npx;
    logic [W-1:0]       npy;
    logic [2:0][W-1:0]  ov;
    logic [W-1:0]       opx;
    logic [W-1:0]       opy;
    status_t            status;
  } pl_t;

  function automatic logic signed [PW-1:0] xw(input logic signed [W-1:0] x);
    xw = PW'(x);
  endfunction

  function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] x);
    if (x > WMAX_P) begin
      sat_w = WMAX_P[W-1:0];
    end else if (x < WMIN_P) begin
      sat_w = WMIN_P[W-1:0];
    end else begin
      sat_w = x[W-1:0];
    end
  endfunction

  // round half up, then floor shift
  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p,
                                               input logic [5:0] sh);
    rnd = (p + $signed(PW'(1) << (sh - 6'd1))) >>> sh;
  endfunction

  function automatic logic signed [W-1:0] mulr(input logic signed [PW-1:0] p);
    mulr = sat_w(rnd(p, 6'(F)));
  endfunction

  pl_t              st_r   [NST];
  pl_t              st_nxt [NST];
  pl_t              st_div [QB];
  logic [NST-1:0]   vld_r;
  logic [NST-1:0]   vld_in;
  logic [NST-1:0]   en;
  logic [RW-1:0]    rem_div [QB][3];
  logic [2:0]       qb_div  [QB];
  logic signed [PW-1:0] dt_p;
  logic             in_acc;
  logic             out_acc;

  assign dt_p = $signed(PW'(cfg.time_step));

  // A stage takes new data when it is empty or its successor takes its data.
  assign en       = ~vld_r | {out_ready, en[NST-1:1]};
  assign vld_in   = {vld_r[NST-2:0], in_valid};
  assign in_ready = en[0];
  assign out_valid = vld_r[LAST];
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (vld_r & ~en) | (vld_in & en);
    end
  end

  for (genvar gk = 0; gk < NST; gk++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en[gk]) begin
        st_r[gk] <= st_nxt[gk];
      end
    end
  end

  // Stage 0: capture the particle, form qm*dt and the half-step cross products.
  always_comb begin
    st_nxt[0] = '0;
    for (int j = 0; j < 3; j++) begin
      st_nxt[0].vo[j] = in_item[j*W +: W];
      st_nxt[0].e[j]  = in_item[(3+j)*W +: W];
      st_nxt[0].b[j]  = in_item[(6+j)*W +: W];
    end
    st_nxt[0].px   = in_item[10*W +: W];
    st_nxt[0].py   = in_item[11*W +: W];
    st_nxt[0].p_hk = xw($signed(in_item[9*W +: W])) * dt_p;
    for (int j = 0; j < 3; j++) begin
      st_nxt[0].pc[2*j]   = xw($signed(in_item[((j+1)%3)*W +: W]))
                          * xw($signed(in_item[(6+(j+2)%3)*W +: W]));
      st_nxt[0].pc[2*j+1] = xw($signed(in_item[((j+2)%3)*W +: W]))
                          * xw($signed(in_item[(6+(j+1)%3)*W +: W]));
    end
  end

  // Stage 1: k = qm*dt/2, Lorentz term E + v x B.
  always_comb begin
    st_nxt[1]    = st_r[0];
    st_nxt[1].hk = sat_w(rnd($signed(st_r[0].p_hk), 6'(F + 1)));
    for (int j = 0; j < 3; j++) begin
      st_nxt[1].l[j] = sat_w(xw($signed(st_r[0].e[j]))
                           + xw(mulr($signed(st_r[0].pc[2*j])))
                           - xw(mulr($signed(st_r[0].pc[2*j+1]))));
    end
  end

  // Stage 2: k*B, k*E, k*L.
  always_comb begin
    st_nxt[2] = st_r[1];
    for (int j = 0; j < 3; j++) begin
      st_nxt[2].p_t[j] = xw($signed(st_r[1].hk)) * xw($signed(st_r[1].b[j]));
      st_nxt[2].p_a[j] = xw($signed(st_r[1].hk)) * xw($signed(st_r[1].e[j]));
      st_nxt[2].p_l[j] = xw($signed(st_r[1].hk)) * xw($signed(st_r[1].l[j]));
    end
  end

  // Stage 3: t, a, and the backward half step when enabled.
  always_comb begin
    st_nxt[3] = st_r[2];
    for (int j = 0; j < 3; j++) begin
      st_nxt[3].t[j] = mulr($signed(st_r[2].p_t[j]));
      st_nxt[3].a[j] = mulr($signed(st_r[2].p_a[j]));
      if (cfg.half) begin
        st_nxt[3].vh[j] = sat_w(xw($signed(st_r[2].vo[j]))
                              - xw(mulr($signed(st_r[2].p_l[j]))));
      end else begin
        st_nxt[3].vh[j] = st_r[2].vo[j];
      end
    end
  end

  // Stage 4: v minus, t*t, rotation angle check.
  always_comb begin
    logic signed [W:0] tw;
    logic [W:0]        mg;
    st_nxt[4]       = st_r[3];
    st_nxt[4].fault = 1'b0;
    for (int j = 0; j < 3; j++) begin
      st_nxt[4].vm[j]   = sat_w(xw($signed(st_r[3].vh[j])) + xw($signed(st_r[3].a[j])));
      st_nxt[4].p_tt[j] = xw($signed(st_r[3].t[j])) * xw($signed(st_r[3].t[j]));
      tw = (W+1)'($signed(st_r[3].t[j]));
      mg = tw[W] ? (W+1)'(-tw) : (W+1)'(tw);
      if ((MGW'(mg) << (30 - F)) > TANL) begin
        st_nxt[4].fault = 1'b1;
      end
    end
  end

  // Stage 5: divider operands for s = 2t/(1+t*t), v minus x t products.
  always_comb begin
    logic signed [W:0]    tw;
    logic [W:0]           mg;
    logic signed [PW-1:0] dfull;
    st_nxt[5] = st_r[4];
    for (int j = 0; j < 3; j++) begin
      tw    = (W+1)'($signed(st_r[4].t[j]));
      mg    = tw[W] ? (W+1)'(-tw) : (W+1)'(tw);
      dfull = xw(mulr($signed(st_r[4].p_tt[j]))) + ONE_P;
      st_nxt[5].den[j] = dfull[DW-1:0];
      st_nxt[5].rem[j] = (RW'(mg[F:0]) << (F + 1)) + RW'(dfull[DW-1:1]);
      st_nxt[5].q[j]   = '0;
      st_nxt[5].pcx[2*j]   = xw($signed(st_r[4].vm[(j+1)%3]))
                           * xw($signed(st_r[4].t[(j+2)%3]));
      st_nxt[5].pcx[2*j+1] = xw($signed(st_r[4].vm[(j+2)%3]))
                           * xw($signed(st_r[4].t[(j+1)%3]));
    end
  end

  // Divider: one quotient bit per stage, most significant first.
  for (genvar gi = 0; gi < QB; gi++) begin : g_div
    for (genvar gj = 0; gj < 3; gj++) begin : g_lane
      bpp_div_stage #(
        .RW (RW),
        .DW (DW),
        .SH (QB - 1 - gi)
      ) u_step (
        .rem_i  (st_r[SDIV-1+gi].rem[gj]),
        .den_i  (st_r[SDIV-1+gi].den[gj]),
        .rem_o  (rem_div[gi][gj]),
        .qbit_o (qb_div[gi][gj])
      );
    end

    always_comb begin
      st_div[gi] = st_r[SDIV-1+gi];
      for (int j = 0; j < 3; j++) begin
        st_div[gi].rem[j]            = rem_div[gi][j];
        st_div[gi].q[j][QB-1-gi]     = qb_div[gi][j];
      end
    end

    if (gi > 0) begin : g_pass
      assign st_nxt[SDIV+gi] = st_div[gi];
    end
  end

  // First divider stage also forms v' = v minus + v minus x t.
  always_comb begin
    st_nxt[SDIV] = st_div[0];
    for (int j = 0; j < 3; j++) begin
      st_nxt[SDIV].vd[j] = sat_w(xw($signed(st_r[SDIV-1].vm[j]))
                               + xw(mulr($signed(st_r[SDIV-1].pcx[2*j])))
                               - xw(mulr($signed(st_r[SDIV-1].pcx[2*j+1]))));
    end
  end

  // Apply the sign of t to the quotient, v' x s products.
  always_comb begin
    logic signed [QB:0] sv [3];
    st_nxt[SD] = st_r[SD-1];
    for (int j = 0; j < 3; j++) begin
      sv[j] = $signed({1'b0, st_r[SD-1].q[j]});
      if (st_r[SD-1].t[j][W-1]) begin
        sv[j] = -sv[j];
      end
    end
    for (int j = 0; j < 3; j++) begin
      st_nxt[SD].p_s[2*j]   = xw($signed(st_r[SD-1].vd[(j+1)%3])) * PW'(sv[(j+2)%3]);
      st_nxt[SD].p_s[2*j+1] = xw($signed(st_r[SD-1].vd[(j+2)%3])) * PW'(sv[(j+1)%3]);
    end
  end

  // v plus
  always_comb begin
    st_nxt[SD+1] = st_r[SD];
    for (int j = 0; j < 3; j++) begin
      st_nxt[SD+1].vp[j] = sat_w(xw($signed(st_r[SD].vm[j]))
                               + xw(mulr($signed(st_r[SD].p_s[2*j])))
                               - xw(mulr($signed(st_r[SD].p_s[2*j+1]))));
    end
  end

  // Second half kick.
  always_comb begin
    st_nxt[SD+2] = st_r[SD+1];
    for (int j = 0; j < 3; j++) begin
      st_nxt[SD+2].vf[j] = sat_w(xw($signed(st_r[SD+1].vp[j]))
                               + xw($signed(st_r[SD+1].a[j])));
    end
  end

  // Velocity sum for Courant, dt*v for the position advance.
  always_comb begin
    logic signed [PW-1:0] sm;
    st_nxt[SD+3] = st_r[SD+2];
    sm = xw($signed(st_r[SD+2].vf[0])) + xw($signed(st_r[SD+2].vf[1]))
       + xw($signed(st_r[SD+2].vf[2]));
    st_nxt[SD+3].sum  = sm[W+1:0];
    st_nxt[SD+3].p_px = dt_p * xw($signed(st_r[SD+2].vf[0]));
    st_nxt[SD+3].p_py = dt_p * xw($signed(st_r[SD+2].vf[1]));
  end

  // sum*dt for the exact Courant compare, advanced positions.
  always_comb begin
    st_nxt[SD+4]     = st_r[SD+3];
    st_nxt[SD+4].pos = ($signed(st_r[SD+3].sum) > 0);
    st_nxt[SD+4].p_c = CW'(st_r[SD+3].sum[W:0]) * CW'(cfg.time_step);
    st_nxt[SD+4].npx = sat_w(xw($signed(st_r[SD+3].px))
                           + xw(mulr($signed(st_r[SD+3].p_px))));
    st_nxt[SD+4].npy = sat_w(xw($signed(st_r[SD+3].py))
                           + xw(mulr($signed(st_r[SD+3].p_py))));
  end

  // Output stage: status and result selection.
  always_comb begin
    logic [CW-1:0] xh;
    logic          stop;
    logic          warn;
    st_nxt[LAST] = st_r[LAST-1];
    xh   = CW'(cfg.cell_length) << F;
    stop = st_r[LAST-1].pos && ((st_r[LAST-1].p_c << 1) > ((xh << 1) + xh));
    warn = st_r[LAST-1].pos && (st_r[LAST-1].p_c > xh);
    if (st_r[LAST-1].fault) begin
      st_nxt[LAST].status = ST_ROT_FAULT;
      st_nxt[LAST].ov     = st_r[LAST-1].vo;
      st_nxt[LAST].opx    = st_r[LAST-1].px;
      st_nxt[LAST].opy    = st_r[LAST-1].py;
    end else if (stop) begin
      st_nxt[LAST].status = ST_CFL_STOP;
      st_nxt[LAST].ov     = st_r[LAST-1].vf;
      st_nxt[LAST].opx    = st_r[LAST-1].px;
      st_nxt[LAST].opy    = st_r[LAST-1].py;
    end else begin
      st_nxt[LAST].status = warn ? ST_CFL_WARN : ST_OK;
      st_nxt[LAST].ov     = st_r[LAST-1].vf;
      st_nxt[LAST].opx    = st_r[LAST-1].npx;
      st_nxt[LAST].opy    = st_r[LAST-1].npy;
    end
  end

  assign out_item   = {st_r[LAST].opy, st_r[LAST].opx, st_r[LAST].ov[2],
                       st_r[LAST].ov[1], st_r[LAST].ov[0]};
  assign out_status = st_r[LAST].status;

  // Items in flight change only by accepted inputs and delivered results.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(vld_r) == $past($countones(vld_r))
      + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("pipeline occupancy lost or duplicated an item");

  // Input backpressure only when the pipe is full up to a stalled output.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r) && !out_ready)
    else $error("input stalled with a bubble in the pipeline");

  // Without a rotation fault |s| stays below one, so the top quotient bit is clear.
  a_quot: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SD-1] && !st_r[SD-1].fault |->
      st_r[SD-1].q[0][QB-1] == 1'b0 && st_r[SD-1].q[1][QB-1] == 1'b0
      && st_r[SD-1].q[2][QB-1] == 1'b0)
    else $error("divider quotient out of range");

  // A Courant stop keeps the incoming position.
  a_stop_pos: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] && st_r[LAST].status == ST_CFL_STOP |->
      st_r[LAST].opx == st_r[LAST].px && st_r[LAST].opy == st_r[LAST].py)
    else $error("position advanced on Courant stop");

endmodule

// ===== rtl/boris_particle_push.sv =====
// Top level of the Boris particle push engine: stream ports, APB registers.
// Depends on bpp_pkg, bpp_cfg_regs and bpp_core.
//
// Boris particle pusher in signed fixed point (WORD_BITS words, FRAC_BITS
// fraction bits, Q16.16 by default). Each input transaction carries one
// particle: velocity, E and B at the particle, charge-to-mass ratio and the
// x/y position. Each accepts produces exactly one output transaction with the
// new velocity, the new position and a status code (ok, rotation fault,
// Courant warning, Courant stop). The engine is a pipeline of FRAC_BITS + 13
// register stages (29 at the default), set mostly by the s-vector divider,
// which resolves one quotient bit per stage. It accepts one particle per clock
// and delivers one per clock while the output is not stalled. Stages compact
// bubbles, so a stalled output only holds the input off once every stage is
// full. Registers: time_step at 0x0, cell_length at 0x4, initial_half_step at
// 0x8; write them only while no particle is in flight.
module boris_particle_push #(
  parameter int WORD_BITS = bpp_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = bpp_pkg::FRAC_BITS_DEF,
  localparam int IN_W  = ((bpp_pkg::NUM_IN_FIELDS * WORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((bpp_pkg::NUM_OUT_WORDS * WORD_BITS + 2 + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // fields from bit 0: vel_x, vel_y, vel_z, efield_x, efield_y, efield_z,
  // bfield_x, bfield_y, bfield_z, charge_to_mass, pos_x, pos_y
  input  logic [IN_W-1:0]            in_tdata,
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // fields from bit 0: new_vel_x, new_vel_y, new_vel_z, new_pos_x,
  // new_pos_y, status (2 bits), zero fill
  output logic [OUT_W-1:0]           out_tdata,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpp_pkg::CFG_AW-1:0] paddr,
  input  logic [bpp_pkg::CFG_DW-1:0] pwdata,
  output logic [bpp_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import bpp_pkg::*;

  localparam int ITEM_W = NUM_IN_FIELDS * WORD_BITS;
  localparam int RES_W  = NUM_OUT_WORDS * WORD_BITS;

  cfg_t              cfg;
  logic [RES_W-1:0]  res_item;
  status_t           res_status;

  bpp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Datapath; fill bits above the packed fields are ignored.
  bpp_core #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_tdata[ITEM_W-1:0]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_item   (res_item),
    .out_status (res_status)
  );

  // Pack status above the five result words and zero the fill.
  assign out_tdata = OUT_W'({res_status, res_item});

endmodule

// ===== dv/boris_particle_push_tb.sv =====
// Self-checking testbench for boris_particle_push: directed table plus random
// particles, checked against an in-bench Boris push predictor. Needs bpp_pkg.
module boris_particle_push_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpp_pkg::*;

  localparam int  IN_W      = 384;
  localparam int  OUT_W     = 168;
  localparam int  LATENCY   = 29;
  localparam int  WDOG_MAX  = 4000;
  localparam int  RAND_ITEMS = 200;
  localparam longint W_MAX  = 64'sd2147483647;
  localparam longint W_MIN  = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] vel [3];
    logic signed [31:0] ef  [3];
    logic signed [31:0] bf  [3];
    logic signed [31:0] qm;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } particle_t;

  typedef struct {
    logic signed [31:0] vel [3];
    logic signed [31:0] px;
    logic signed [31:0] py;
    status_t            status;
  } push_res_t;

  typedef struct {
    particle_t p;
    bit        typed;
    push_res_t r;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // fields from bit 0: vel_x/y/z, efield_x/y/z, bfield_x/y/z, charge_to_mass, pos_x, pos_y
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // fields from bit 0: new_vel_x/y/z, new_pos_x, new_pos_y, status, zero fill
  logic [OUT_W-1:0]  out_tdata;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  boris_particle_push i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the block's registers, used by the predictor
  longint unsigned   dt_q = 655, h_q = 65536;
  bit                half_q = 1'b0;

  push_res_t         expected_q [$];
  int                errs = 0;
  int                n_sent = 0, n_got = 0;
  int                status_seen [4] = '{0, 0, 0, 0};
  bit                idle_on = 1'b1;
  bit                done = 1'b0;
  int                quiet_cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic longint sat32(longint x);
    if (x > W_MAX) return W_MAX;
    if (x < W_MIN) return W_MIN;
    return x;
  endfunction

  // exact product, round half up, floor to Q16.16, saturate
  function automatic longint qmul(longint a, longint b);
    return sat32((a * b + 64'sd32768) >>> 16);
  endfunction

  function automatic longint s_from_t(longint t);
    longint unsigned mag, d, q;
    mag = (t < 0) ? -t : t;
    d = 64'd65536 + qmul(t, t);
    q = (((2 * mag) << 16) + d / 2) / d;
    return (t < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic push_res_t boris_predict(particle_t p);
    push_res_t r;
    longint v [3], e [3], b [3], a [3], t [3], s [3], vm [3], vd [3], vp [3];
    longint hk, px, py, sum, l [3];
    longint unsigned mag, x, us;
    bit fault;
    status_t st;
    for (int j = 0; j < 3; j++) begin
      v[j] = p.vel[j]; e[j] = p.ef[j]; b[j] = p.bf[j];
    end
    px = p.px; py = p.py;
    st = ST_OK;
    fault = 1'b0;
    hk = sat32((longint'(p.qm) * longint'(dt_q) + 64'sd65536) >>> 17);
    for (int j = 0; j < 3; j++) begin
      t[j] = qmul(hk, b[j]);
      mag = (t[j] < 0) ? -t[j] : t[j];
      if ((mag << 14) > TAN_LIMIT_Q30) fault = 1'b1;
    end
    if (fault) begin
      // rotation too large: everything passes through
      st = ST_ROT_FAULT;
    end else begin
      if (half_q) begin
        l[0] = sat32(e[0] + qmul(b[2], v[1]) - qmul(b[1], v[2]));
        l[1] = sat32(e[1] + qmul(b[0], v[2]) - qmul(b[2], v[0]));
        l[2] = sat32(e[2] + qmul(b[1], v[0]) - qmul(b[0], v[1]));
        for (int j = 0; j < 3; j++) v[j] = sat32(v[j] - qmul(hk, l[j]));
      end
      for (int j = 0; j < 3; j++) begin
        a[j]  = qmul(hk, e[j]);
        s[j]  = s_from_t(t[j]);
        vm[j] = sat32(v[j] + a[j]);
      end
      vd[0] = sat32(vm[0] + qmul(vm[1], t[2]) - qmul(vm[2], t[1]));
      vd[1] = sat32(vm[1] + qmul(vm[2], t[0]) - qmul(vm[0], t[2]));
      vd[2] = sat32(vm[2] + qmul(vm[0], t[1]) - qmul(vm[1], t[0]));
      vp[0] = sat32(vm[0] + qmul(vd[1], s[2]) - qmul(vd[2], s[1]));
      vp[1] = sat32(vm[1] + qmul(vd[2], s[0]) - qmul(vd[0], s[2]));
      vp[2] = sat32(vm[2] + qmul(vd[0], s[1]) - qmul(vd[1], s[0]));
      for (int j = 0; j < 3; j++) v[j] = sat32(vp[j] + a[j]);
      // Courant check, compared exactly against 1.5 and 1.0
      sum = v[0] + v[1] + v[2];
      if (dt_q > 0 && sum > 0) begin
        x  = h_q << 16;
        us = sum;
        if (2 * us > (3 * x) / dt_q) st = ST_CFL_STOP;
        else if (us > x / dt_q)      st = ST_CFL_WARN;
      end
      if (st != ST_CFL_STOP) begin
        px = sat32(px + qmul(dt_q, v[0]));
        py = sat32(py + qmul(dt_q, v[1]));
      end
    end
    for (int j = 0; j < 3; j++) r.vel[j] = v[j][31:0];
    r.px = px[31:0];
    r.py = py[31:0];
    r.status = st;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: case ($urandom_range(0, 4))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0;
           3: return 32'h1;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $signed($urandom) >>> $urandom_range(6, 30);
    endcase
  endfunction

  // mostly tiny magnitudes so the rotation stays under the limit
  function automatic logic [31:0] rand_tiny();
    if ($urandom_range(0, 9) == 0) return rand_word();
    return $signed($urandom) >>> $urandom_range(14, 31);
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    longint unsigned vlim;
    for (int j = 0; j < 3; j++) begin
      p.vel[j] = rand_word();
      p.ef[j]  = rand_word();
      p.bf[j]  = rand_tiny();
    end
    p.qm = rand_tiny();
    p.px = rand_word();
    p.py = rand_word();
    // aim a share of particles just past the Courant warning level
    if ($urandom_range(0, 9) < 2 && dt_q > 0) begin
      vlim = ((h_q << 16) / dt_q) * $urandom_range(101, 160) / 100;
      if (vlim < 64'h7FFF_FFFF) begin
        p.vel[0] = vlim[31:0];
        p.vel[1] = '0;
        p.vel[2] = '0;
        p.qm     = '0;
      end
    end
    return p;
  endfunction

  function automatic particle_t fill_particle(logic [31:0] v, logic [31:0] e,
                                              logic [31:0] b, logic [31:0] q,
                                              logic [31:0] pos);
    particle_t p;
    for (int j = 0; j < 3; j++) begin
      p.vel[j] = v; p.ef[j] = e; p.bf[j] = b;
    end
    p.qm = q; p.px = pos; p.py = ~pos;
    return p;
  endfunction

  function automatic push_res_t pass_through(particle_t p, status_t st);
    push_res_t r;
    for (int j = 0; j < 3; j++) r.vel[j] = p.vel[j];
    r.px = p.px; r.py = p.py; r.status = st;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  // Drive one particle; start and end at a falling edge.
  task automatic send_particle(particle_t p, bit typed, push_res_t r_typed);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.py, p.px, p.qm, p.bf[2], p.bf[1], p.bf[0],
                  p.ef[2], p.ef[1], p.ef[0], p.vel[2], p.vel[1], p.vel[0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(typed ? r_typed : boris_predict(p));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drain the pipeline, then load a new register setting.
  task automatic set_regs(longint unsigned dt, longint unsigned h, bit half);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    apb_write(REG_TIME_STEP, dt[31:0]);
    apb_write(REG_CELL_LENGTH, h[31:0]);
    apb_write(REG_HALF_STEP, {31'b0, half});
    dt_q = dt; h_q = h; half_q = half;
  endtask

  // ---------------------------------------------------------------- receiver
  // Random back pressure; hold off once for a long stretch to fill the pipe.
  initial begin
    int gap;
    bit held = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (!held && n_got >= 300) begin
        gap  = 400;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    push_res_t want;
    logic [31:0] got [5];
    logic [1:0]  got_st;
    if (rst_n && out_tvalid && out_tready) begin
      for (int j = 0; j < 5; j++) got[j] = out_tdata[32*j +: 32];
      got_st = out_tdata[161:160];
      n_got++;
      status_seen[got_st]++;
      if (expected_q.size() == 0) begin
        $error("result with nothing outstanding");
        errs++;
      end else begin
        want = expected_q.pop_front();
        for (int j = 0; j < 3; j++)
          if (got[j] !== want.vel[j]) begin
            $error("new_vel[%0d]: expected %h, got %h", j, want.vel[j], got[j]);
            errs++;
          end
        if (got[3] !== want.px) begin
          $error("new_pos_x: expected %h, got %h", want.px, got[3]);
          errs++;
        end
        if (got[4] !== want.py) begin
          $error("new_pos_y: expected %h, got %h", want.py, got[4]);
          errs++;
        end
        if (got_st !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got_st);
          errs++;
        end
      end
    end
  end

  // watchdog: count cycles with no transaction on either stream
  always @(posedge clk) begin
    if (!rst_n || done || (in_tvalid && in_tready) || (out_tvalid && out_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    push_res_t none;
    longint unsigned settings [5][3];
    int w;
    settings = '{'{655, 65536, 1}, '{0, 65536, 0}, '{64'h7FFF_FFFF, 1, 1},
                 '{6554, 64'h7FFF_FFFF, 0}, '{65536, 65536, 1}};

    // all zero: nothing moves
    row.p = fill_particle(0, 0, 0, 0, 0);
    row.typed = 1; row.r = pass_through(row.p, ST_OK);
    rows.push_back(row);
    // huge positive and negative q/m against unit and full-scale B: rotation fault
    row.p = fill_particle(32'h0001_0000, 32'h1234_5678, 32'h0001_0000, 32'h7FFF_FFFF,
                          32'h8000_0000);
    row.r = pass_through(row.p, ST_ROT_FAULT);
    rows.push_back(row);
    row.p = fill_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF);
    row.r = pass_through(row.p, ST_ROT_FAULT);
    rows.push_back(row);
    // no force, full-scale velocity: Courant stop, position held
    row.p = fill_particle(32'h7FFF_FFFF, 0, 0, 0, 32'h0BAD_F00D);
    row.r = pass_through(row.p, ST_CFL_STOP);
    rows.push_back(row);
    // remaining rows go through the predictor
    row.typed = 0;
    row.p = fill_particle(32'h8000_0000, 0, 0, 0, 32'h8000_0000);
    rows.push_back(row);
    row.p = fill_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0100,
                          32'h7FFF_FFFF);
    rows.push_back(row);
    row.p = fill_particle(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000,
                          32'h0000_0001);
    rows.push_back(row);
    row.p = fill_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF);
    rows.push_back(row);
    // velocity x just above h/dt at reset settings: Courant warning
    row.p = fill_particle(0, 0, 0, 0, 32'h0010_0000);
    row.p.vel[0] = 32'd7_000_000;
    rows.push_back(row);
    // just above 1.5: stop
    row.p.vel[0] = 32'd10_000_000;
    rows.push_back(row);
    // a tilted B field well past the rotation limit
    row.p = fill_particle(32'h0003_0000, 32'h0000_4000, 32'h0020_0000, 32'h0100_0000,
                          32'h0000_0000);
    row.p.bf[1] = 32'hFFE0_0000;
    rows.push_back(row);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table at reset register values
    foreach (rows[i]) send_particle(rows[i].p, rows[i].typed, rows[i].r);

    // random phases, one per register setting
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) set_regs(settings[ph-1][0], settings[ph-1][1], settings[ph-1][2][0]);
      idle_on = (ph != 2);
      for (int k = 0; k < RAND_ITEMS; k++) send_particle(rand_particle(), 0, none);
      in_tvalid <= 1'b0;
    end
    idle_on = 1'b1;

    // drain, then keep watching for stray results
    w = 0;
    while (expected_q.size() != 0 && w < 20000) begin
      @(negedge clk);
      w++;
    end
    repeat (3 * LATENCY) @(negedge clk);
    done = 1'b1;
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      errs++;
    end

    $display("Pushed %0d particles over 6 register settings, %0d results checked.",
             n_sent, n_got);
    $display("Status mix: ok %0d, rotation %0d, warning %0d, stop %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errs == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
